// File: hw/rtl/mavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter package
// Widths, register indexes and reset values shared by the filter files.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // Store geometry and sample width
  localparam int DEPTH       = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int SLOT_BITS   = $clog2(DEPTH);

  // Window length register and running sum
  localparam int WLEN_BITS = 7;
  localparam int SUM_BITS  = 22;
  localparam int PROD_BITS = SAMPLE_BITS + WLEN_BITS + 1;

  // Divider: one quotient bit per step, remainder wide enough for 2 * length
  localparam int REM_BITS  = WLEN_BITS + 1;
  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = SAMPLE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_START_VALUE   = CFG_IDX_BITS'(1);

  localparam logic [WLEN_BITS-1:0]   WLEN_RESET  = WLEN_BITS'(8);
  localparam logic [SAMPLE_BITS-1:0] START_RESET = '0;

  // Length actually used: zero acts as one, anything above the depth as the depth
  function automatic logic [WLEN_BITS-1:0] eff_length(input logic [WLEN_BITS-1:0] n);
    logic [WLEN_BITS-1:0] r;
    if (n == '0) begin
      r = WLEN_BITS'(1);
    end else if (32'(n) > DEPTH) begin
      r = WLEN_BITS'(DEPTH);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mavg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average sample channel
// Valid/ready channel carrying one signed sensor sample per word.
// ----------------------------------------------------------------------------
interface mavg_in_if import mavg_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

// File: hw/rtl/mavg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average result channel
// Valid/ready channel carrying one signed window average per word.
// ----------------------------------------------------------------------------
interface mavg_out_if import mavg_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);

endinterface

// File: hw/rtl/moving_average_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter
// Boxcar average over the last window_length samples, ring store in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries signed samples, out_ch one average per sample, in order.
//   A word is taken when valid and ready are both high at a clock edge.
//   cfg_we/cfg_idx/cfg_data write window_length (index 0, low 7 bits) or
//   start_value (index 1); either write restarts the window: every entry
//   reads as start_value again and the sum is reloaded. Write only when idle.
// Timing:
//   The sample is taken, the replaced entry is read from the store, the sum
//   is updated and written back, then a restoring divider produces one
//   quotient bit per cycle over the 22-bit sum. One sample is in flight at
//   a time: in_ch.ready is low until the average has been handed over.
// Stall:
//   The result sits in the output register until taken; a finished division
//   waits for that register, and in_ch.ready stays low meanwhile.
// Reset:
//   rst_n (synchronous) restores window_length 8, start_value 0, an empty
//   window and a zero sum. Store contents need no clearing: per-entry
//   valid bits mark what has been written.
// ----------------------------------------------------------------------------
module moving_average_filter import mavg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  mavg_in_if.sink                  in_ch,
  mavg_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Configuration and window state
  logic        [WLEN_BITS-1:0]   wlen_r, wlen_nxt;
  logic signed [SAMPLE_BITS-1:0] start_r, start_nxt;
  logic        [DEPTH-1:0]       written_r, written_nxt;
  logic        [SLOT_BITS-1:0]   wslot_r, wslot_nxt;
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;

  // Per-sample working registers
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic        [SLOT_BITS-1:0]   slot_r, slot_nxt;
  logic        [SUM_BITS-1:0]    dq_r, dq_nxt;
  logic        [REM_BITS-1:0]    rem_r, rem_nxt;
  logic        [STEP_BITS-1:0]   step_r, step_nxt;
  logic                          neg_r, neg_nxt;

  // Output register
  logic                          ovalid_r, ovalid_nxt;
  logic signed [SAMPLE_BITS-1:0] avg_r, avg_nxt;

  // Sample store
  logic signed [SAMPLE_BITS-1:0] store [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          rd_en, wr_en;
  logic        [SLOT_BITS-1:0]   rd_addr;

  // Combinational helpers
  logic                          in_acc, cfg_hit;
  logic        [WLEN_BITS-1:0]   len_cur, len_new;
  logic        [SLOT_BITS-1:0]   slot_sel, slot_inc;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SUM_BITS-1:0]    sum_upd;
  logic signed [PROD_BITS-1:0]   restart_prod;
  logic        [REM_BITS-1:0]    trial, trial_diff;
  logic        [SUM_BITS-1:0]    quot_signed;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = ovalid_r;
  assign out_ch.average = avg_r;

  assign len_cur = eff_length(wlen_r);

  // Slot for this sample: falls back to zero if it lies beyond the window
  assign slot_sel = (32'(wslot_r) >= 32'(len_cur)) ? '0 : wslot_r;
  assign rd_addr  = slot_sel;
  assign rd_en    = in_acc;

  // Replaced entry, start_value where never written since the restart
  assign old_val = written_r[slot_r] ? rd_data_r : start_r;
  assign sum_upd = sum_r - SUM_BITS'(old_val) + SUM_BITS'(smp_r);
  assign wr_en   = (state_r == S_READ);

  // Next ring slot with wrap at the window length
  always_comb begin
    slot_inc = slot_r + SLOT_BITS'(1);
    if (32'(slot_r) + 1 >= 32'(len_cur)) begin
      slot_inc = '0;
    end
  end

  // Restart sum from the values being written
  assign cfg_hit = cfg_we && (cfg_idx == REG_WINDOW_LENGTH || cfg_idx == REG_START_VALUE);
  assign len_new = eff_length(wlen_nxt);
  assign restart_prod = $signed(start_nxt) * $signed({1'b0, len_new});

  // Restoring divide step
  assign trial      = {rem_r[REM_BITS-2:0], dq_r[SUM_BITS-1]};
  assign trial_diff = trial - REM_BITS'(len_cur);
  assign quot_signed = neg_r ? (SUM_BITS'(0) - dq_r) : dq_r;

  // Configuration register updates
  always_comb begin
    wlen_nxt  = wlen_r;
    start_nxt = start_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_WINDOW_LENGTH: wlen_nxt  = cfg_data[WLEN_BITS-1:0];
        REG_START_VALUE:   start_nxt = $signed(cfg_data[SAMPLE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    written_nxt = written_r;
    wslot_nxt   = wslot_r;
    sum_nxt     = sum_r;
    smp_nxt     = smp_r;
    slot_nxt    = slot_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    step_nxt    = step_r;
    neg_nxt     = neg_r;
    ovalid_nxt  = ovalid_r;
    avg_nxt     = avg_r;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          smp_nxt   = in_ch.sample;
          slot_nxt  = slot_sel;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Update sum, mark entry, advance slot, load divider with |sum|
        sum_nxt              = sum_upd;
        written_nxt[slot_r]  = 1'b1;
        wslot_nxt            = slot_inc;
        neg_nxt              = sum_upd[SUM_BITS-1];
        dq_nxt               = sum_upd[SUM_BITS-1] ? (SUM_BITS'(0) - sum_upd) : sum_upd;
        rem_nxt              = '0;
        step_nxt             = STEP_BITS'(SUM_BITS);
        state_nxt            = S_DIV;
      end
      S_DIV: begin
        if (trial >= REM_BITS'(len_cur)) begin
          rem_nxt = trial_diff;
          dq_nxt  = {dq_r[SUM_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          dq_nxt  = {dq_r[SUM_BITS-2:0], 1'b0};
        end
        step_nxt = step_r - STEP_BITS'(1);
        if (step_r == STEP_BITS'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand over once the output register is free
        if (!ovalid_r || out_ch.ready) begin
          avg_nxt    = $signed(quot_signed[SAMPLE_BITS-1:0]);
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Restart on a register write (to be issued only while idle; the block does not enforce this)
    if (cfg_hit) begin
      written_nxt = '0;
      wslot_nxt   = '0;
      sum_nxt     = restart_prod[SUM_BITS-1:0];
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wlen_r    <= WLEN_RESET;
      start_r   <= START_RESET;
      written_r <= '0;
      wslot_r   <= '0;
      sum_r     <= '0;
      ovalid_r  <= 1'b0;
      step_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      wlen_r    <= wlen_nxt;
      start_r   <= start_nxt;
      written_r <= written_nxt;
      wslot_r   <= wslot_nxt;
      sum_r     <= sum_nxt;
      ovalid_r  <= ovalid_nxt;
      step_r    <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    smp_r  <= smp_nxt;
    slot_r <= slot_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    avg_r  <= avg_nxt;
  end

  // Sample store: read at accept, write back in the cycle after; the next read
  // cannot be issued before the write since one sample is in flight at a time
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
    end
    if (wr_en) begin
      store[slot_r] <= smp_r;
    end
  end

endmodule
